/* rtl/bed_pkg.sv */
// Shared types, constants and helpers for the backslash escape decoder.
package bed_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_OCT    = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_STOP   = 3'd4
    } bed_mode_t;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_BEL    = 8'h07;
    localparam logic [7:0] CHAR_BS     = 8'h08;
    localparam logic [7:0] CHAR_ESCAPE = 8'h1B;
    localparam logic [7:0] CHAR_FF     = 8'h0C;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_VT     = 8'h0B;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_SEVEN  = 8'h37;
    localparam logic [1:0] OCT_LIMIT   = 2'd3;
    localparam logic [1:0] HEX_LIMIT   = 2'd2;

    typedef struct packed {
        bed_mode_t  mode;
        logic [7:0] accum;
        logic [1:0] count;
    } bed_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_marker;
        logic       stop_seen;
        logic       last_of_run;
    } bed_result_t;

    localparam bed_state_t STATE_RESET = '{mode: MODE_NORMAL, accum: 8'd0, count: 2'd0};

    function automatic bed_result_t make_result(logic [7:0] b, logic endm, logic stop);
        bed_result_t r;
        r.out_byte    = b;
        r.end_marker  = endm;
        r.stop_seen   = stop;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

/* rtl/bed_in_if.sv */
// Input channel carrying one string byte or an end-of-string beat.
interface bed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       string_end;

    modport source (output valid, output char_in, output string_end, input ready);
    modport sink   (input valid, input char_in, input string_end, output ready);
endinterface

/* rtl/bed_out_if.sv */
// Output channel carrying one decoded byte or end marker per beat.
interface bed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_marker;
    logic       stop_seen;
    logic       last_of_run;

    modport source (output valid, output out_byte, output end_marker, output stop_seen,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input end_marker, input stop_seen,
                    input last_of_run, output ready);
endinterface

/* rtl/bed_decode.sv */
// Combinational escape decode of one input beat against the current decoder state.
module bed_decode
    import bed_pkg::*;
(
    input  logic [7:0]  char_in,
    input  logic        string_end,
    input  bed_state_t  state_cur,
    output bed_state_t  state_next,
    output logic [1:0]  res_count,
    output bed_result_t res0,
    output bed_result_t res1
);

    logic       oct_digit;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic [7:0] acc_oct;
    logic [7:0] acc_hex;
    logic [1:0] cnt_inc;

    always_comb
    begin
        oct_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_SEVEN);
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if ((char_in >= "0") && (char_in <= "9"))
        begin
            hex_val = char_in[3:0];
        end
        else if (((char_in >= "a") && (char_in <= "f")) ||
                 ((char_in >= "A") && (char_in <= "F")))
        begin
            hex_val = char_in[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
        acc_oct = {state_cur.accum[4:0], char_in[2:0]};
        acc_hex = {state_cur.accum[3:0], hex_val};
        cnt_inc = state_cur.count + 2'd1;
    end

    always_comb
    begin
        state_next = state_cur;
        res_count  = 2'd0;
        res0       = make_result(8'd0, 1'b0, 1'b0);
        res1       = make_result(8'd0, 1'b0, 1'b0);
        if (string_end)
        begin
            state_next = STATE_RESET;
            case (state_cur.mode)
                MODE_ESC:
                begin
                    res0      = make_result(CHAR_BSLASH, 1'b0, 1'b0);
                    res1      = make_result(8'd0, 1'b1, 1'b0);
                    res_count = 2'd2;
                end
                MODE_OCT, MODE_HEX:
                begin
                    res0      = make_result(state_cur.accum, 1'b0, 1'b0);
                    res1      = make_result(8'd0, 1'b1, 1'b0);
                    res_count = 2'd2;
                end
                MODE_STOP:
                begin
                    res0      = make_result(8'd0, 1'b1, 1'b1);
                    res_count = 2'd1;
                end
                default:
                begin
                    res0      = make_result(8'd0, 1'b1, 1'b0);
                    res_count = 2'd1;
                end
            endcase
        end
        else
        begin
            case (state_cur.mode)
                MODE_ESC:
                begin
                    state_next.mode = MODE_NORMAL;
                    res_count       = 2'd1;
                    case (char_in)
                        "a":         res0 = make_result(CHAR_BEL, 1'b0, 1'b0);
                        "b":         res0 = make_result(CHAR_BS, 1'b0, 1'b0);
                        "e":         res0 = make_result(CHAR_ESCAPE, 1'b0, 1'b0);
                        "f":         res0 = make_result(CHAR_FF, 1'b0, 1'b0);
                        "n":         res0 = make_result(CHAR_LF, 1'b0, 1'b0);
                        "r":         res0 = make_result(CHAR_CR, 1'b0, 1'b0);
                        "t":         res0 = make_result(CHAR_TAB, 1'b0, 1'b0);
                        "v":         res0 = make_result(CHAR_VT, 1'b0, 1'b0);
                        CHAR_BSLASH: res0 = make_result(CHAR_BSLASH, 1'b0, 1'b0);
                        default:
                        begin
                            res_count = 2'd0;
                            if (char_in == "c")
                            begin
                                state_next.mode = MODE_STOP;
                            end
                            else if (char_in == CHAR_ZERO)
                            begin
                                state_next = '{mode: MODE_OCT, accum: 8'd0, count: 2'd0};
                            end
                            else if (oct_digit)
                            begin
                                state_next = '{mode: MODE_OCT, accum: {5'd0, char_in[2:0]},
                                               count: 2'd1};
                            end
                            else if (char_in == "x")
                            begin
                                state_next = '{mode: MODE_HEX, accum: 8'd0, count: 2'd0};
                            end
                            else
                            begin
                                res0      = make_result(CHAR_BSLASH, 1'b0, 1'b0);
                                res1      = make_result(char_in, 1'b0, 1'b0);
                                res_count = 2'd2;
                            end
                        end
                    endcase
                end
                MODE_OCT, MODE_HEX:
                begin
                    if ((state_cur.mode == MODE_OCT) ? oct_digit : hex_ok)
                    begin
                        state_next.accum = (state_cur.mode == MODE_OCT) ? acc_oct : acc_hex;
                        state_next.count = cnt_inc;
                        if ((state_cur.mode == MODE_OCT) ? (cnt_inc == OCT_LIMIT)
                                                         : (cnt_inc >= HEX_LIMIT))
                        begin
                            res0       = make_result(state_next.accum, 1'b0, 1'b0);
                            res_count  = 2'd1;
                            state_next = STATE_RESET;
                        end
                    end
                    else
                    begin
                        res0             = make_result(state_cur.accum, 1'b0, 1'b0);
                        state_next.accum = 8'd0;
                        state_next.count = 2'd0;
                        if (char_in == CHAR_BSLASH)
                        begin
                            state_next.mode = MODE_ESC;
                            res_count       = 2'd1;
                        end
                        else
                        begin
                            state_next.mode = MODE_NORMAL;
                            res1            = make_result(char_in, 1'b0, 1'b0);
                            res_count       = 2'd2;
                        end
                    end
                end
                MODE_STOP:
                begin
                    res_count = 2'd0;
                end
                default:
                begin
                    if (char_in == CHAR_BSLASH)
                    begin
                        state_next.mode = MODE_ESC;
                    end
                    else
                    begin
                        state_next.mode = MODE_NORMAL;
                        res0            = make_result(char_in, 1'b0, 1'b0);
                        res_count       = 2'd1;
                    end
                end
            endcase
        end
        if (res_count == 2'd1)
        begin
            res0.last_of_run = 1'b1;
        end
        if (res_count == 2'd2)
        begin
            res1.last_of_run = 1'b1;
        end
    end

endmodule

/* rtl/backslash_escape_decoder.sv */
// Top level of the streaming backslash escape decoder with a two-entry result buffer.
// The first result of a beat is registered and appears on the output in the cycle after the beat is accepted.
// Throughput: one input beat per cycle while each beat gives at most one result and the output is not stalled.
// A beat that gives two results stalls the input while its second result waits in the result buffer.
// Reset clears the decode mode, accumulated value, digit count and both result valid bits.
module backslash_escape_decoder
    import bed_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    bed_in_if.sink    in_ch,
    bed_out_if.source out_ch
);

    bed_state_t  state_reg;
    bed_state_t  state_next;
    logic [1:0]  res_count;
    bed_result_t res0;
    bed_result_t res1;
    bed_result_t out_reg;
    bed_result_t out_next;
    bed_result_t sec_reg;
    bed_result_t sec_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        sec_valid_reg;
    logic        sec_valid_next;
    logic        accept;
    logic        take;

    bed_decode u_decode (
        .char_in    (in_ch.char_in),
        .string_end (in_ch.string_end),
        .state_cur  (state_reg),
        .state_next (state_next),
        .res_count  (res_count),
        .res0       (res0),
        .res1       (res1)
    );

    assign in_ch.ready = !sec_valid_reg && (!out_valid_reg || out_ch.ready);
    assign accept      = in_ch.valid && in_ch.ready;
    assign take        = out_valid_reg && out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        sec_valid_next = sec_valid_reg;
        out_next       = out_reg;
        sec_next       = sec_reg;
        if (accept)
        begin
            out_valid_next = (res_count != 2'd0);
            sec_valid_next = (res_count == 2'd2);
            out_next       = res0;
            sec_next       = res1;
        end
        else if (take)
        begin
            out_valid_next = sec_valid_reg;
            sec_valid_next = 1'b0;
            out_next       = sec_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        sec_reg <= sec_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_reg.out_byte;
    assign out_ch.end_marker  = out_reg.end_marker;
    assign out_ch.stop_seen   = out_reg.stop_seen;
    assign out_ch.last_of_run = out_reg.last_of_run;

    // The second buffer entry is only ever filled behind a valid head entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        sec_valid_reg |-> out_valid_reg)
        else $error("second result buffered without a head result");

    // A head result that is not the last of its beat always has its partner waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last_of_run) |-> sec_valid_reg)
        else $error("first of two results shown without the second buffered");

    // An end-of-string beat always produces output and returns the decoder to normal text.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.string_end) |=> (out_valid_reg && state_reg == STATE_RESET))
        else $error("end of string did not produce output or reset the state");

    // A stop escape never lets ordinary bytes through.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && state_reg.mode == MODE_STOP && !in_ch.string_end) |=> !out_valid_reg)
        else $error("byte emitted while output is stopped");

endmodule
